// ----- design/hlc_pkg.sv -----
// ============================================================================
// hlc_pkg
// Shared types, constants and helpers of the hash message length counter.
// ============================================================================
package hlc_pkg;

    localparam int MAX_WORDS = 4;
    localparam int WORD_W    = 32;
    localparam int CNT_W     = $clog2(MAX_WORDS + 1);

    localparam int OP_W       = 2;
    localparam int LEN_W      = 32;
    localparam int WC_W       = 3;
    localparam int EXP_W      = 8;
    localparam int OFS_W      = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam int OUT_W      = 64;
    localparam int BIT_SHIFT  = 3;
    localparam int SH_W       = $clog2(WORD_W);
    localparam int WIDX_W     = EXP_W - SH_W;

    localparam logic [OP_W-1:0] OP_ADD     = 2'd0;
    localparam logic [OP_W-1:0] OP_CLEAR   = 2'd1;
    localparam logic [OP_W-1:0] OP_TO_BITS = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_WORD_COUNT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LIMIT_EXP  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LIMIT_OFS  = 2'd2;

    localparam logic [WC_W-1:0]  WORD_COUNT_RST = 3'd2;

    typedef logic [WORD_W-1:0]                 word_t;
    typedef logic [MAX_WORDS-1:0][WORD_W-1:0]  words_t;
    typedef logic [CNT_W-1:0]                  cnt_t;

    typedef struct packed {
        logic err;      // direct limit check failed
        logic trial;    // offset check pending on the new count
    } upd_flags_t;

    // Words in use: zero acts as one, anything above the array depth saturates.
    function automatic cnt_t active_words(input logic [WC_W-1:0] wc);
        cnt_t n;
        if (wc == '0)
            n = CNT_W'(1);
        else if (int'(wc) > MAX_WORDS)
            n = CNT_W'(MAX_WORDS);
        else
            n = CNT_W'(wc);
        return n;
    endfunction

    function automatic word_t limit_value(input logic [EXP_W-1:0] expo);
        return word_t'(1) << expo[SH_W-1:0];
    endfunction

    function automatic logic [WIDX_W-1:0] limit_index(input logic [EXP_W-1:0] expo);
        return expo[EXP_W-1:SH_W];
    endfunction

endpackage

// ----- design/hlc_in_if.sv -----
// ============================================================================
// hlc_in_if
// Input channel: one operation beat with its length.
// ============================================================================
interface hlc_in_if;
    logic                       valid;
    logic                       ready;
    logic [hlc_pkg::OP_W-1:0]   op;
    logic [hlc_pkg::LEN_W-1:0]  add_length;

    modport source (output valid, output op, output add_length, input ready);
    modport sink   (input valid, input op, input add_length, output ready);
endinterface

// ----- design/hlc_out_if.sv -----
// ============================================================================
// hlc_out_if
// Result channel: status and the counter words after the operation.
// ============================================================================
interface hlc_out_if;
    logic                       valid;
    logic                       ready;
    logic                       status;
    logic [hlc_pkg::OUT_W-1:0]  count_low;
    logic [hlc_pkg::OUT_W-1:0]  count_high;

    modport source (output valid, output status, output count_low, output count_high,
                    input ready);
    modport sink   (input valid, input status, input count_low, input count_high,
                    output ready);
endinterface

// ----- design/hlc_update.sv -----
// ============================================================================
// hlc_update
// Next counter value for one operation, with the direct limit check.
// ============================================================================
module hlc_update (
    input  hlc_pkg::words_t                 cur,
    input  hlc_pkg::cnt_t                   n,
    input  logic [hlc_pkg::OP_W-1:0]        op,
    input  logic [hlc_pkg::LEN_W-1:0]       add_length,
    input  logic [hlc_pkg::EXP_W-1:0]       limit_exponent,
    input  logic [hlc_pkg::OFS_W-1:0]       limit_offset,
    output hlc_pkg::words_t                 nxt,
    output hlc_pkg::upd_flags_t             flags
);

    logic [hlc_pkg::WORD_W:0]           sum0;
    hlc_pkg::words_t                    sums;
    hlc_pkg::words_t                    shl;
    logic [hlc_pkg::MAX_WORDS-1:0]      ovf;
    logic [hlc_pkg::MAX_WORDS-1:0]      reach;
    logic [hlc_pkg::MAX_WORDS-1:0]      active;
    logic [hlc_pkg::MAX_WORDS-1:0]      hit;
    logic                               wrap;
    logic                               err;
    logic                               chk_on;
    logic [hlc_pkg::WIDX_W-1:0]         idx;
    hlc_pkg::word_t                     lim;

    always_comb
    begin
        chk_on = (limit_offset == '0) && (limit_exponent != '0);
        idx    = hlc_pkg::limit_index(limit_exponent);
        lim    = hlc_pkg::limit_value(limit_exponent);
        sum0   = {1'b0, cur[0]} + {1'b0, add_length};

        // carry ripple: word 0 takes the length, the rest take a single carry
        for (int i = 0; i < hlc_pkg::MAX_WORDS; i++)
        begin
            sums[i]   = cur[i] + hlc_pkg::WORD_W'(1);
            ovf[i]    = &cur[i];
            active[i] = hlc_pkg::CNT_W'(i) < n;
            shl[i]    = cur[i] << hlc_pkg::BIT_SHIFT;
        end
        sums[0]  = sum0[hlc_pkg::WORD_W-1:0];
        ovf[0]   = sum0[hlc_pkg::WORD_W];
        reach[0] = 1'b1;
        for (int i = 1; i < hlc_pkg::MAX_WORDS; i++)
        begin
            reach[i] = reach[i-1] & ovf[i-1];
            shl[i][hlc_pkg::BIT_SHIFT-1:0] =
                cur[i-1][hlc_pkg::WORD_W-1 -: hlc_pkg::BIT_SHIFT];
        end

        wrap = 1'b0;
        for (int i = 0; i < hlc_pkg::MAX_WORDS; i++)
        begin
            hit[i] = chk_on && (int'(idx) == i) && active[i] && reach[i] && (cur[i] > lim);
            wrap   = wrap | ((hlc_pkg::CNT_W'(i + 1) == n) && reach[i] && ovf[i]);
        end
        err = |hit;

        nxt = cur;
        case (op)
            hlc_pkg::OP_ADD:
            begin
                for (int i = 0; i < hlc_pkg::MAX_WORDS; i++)
                begin
                    if (err)
                    begin
                        // words below the checked one keep their sums
                        if (reach[i] && (int'(idx) > i))
                            nxt[i] = sums[i];
                    end
                    else if (wrap)
                    begin
                        if (active[i])
                            nxt[i] = (i == 0) ? hlc_pkg::WORD_W'(1) : '0;
                    end
                    else if (active[i] && reach[i])
                    begin
                        nxt[i] = sums[i];
                    end
                end
            end
            hlc_pkg::OP_CLEAR:
            begin
                for (int i = 0; i < hlc_pkg::MAX_WORDS; i++)
                    if (active[i])
                        nxt[i] = '0;
            end
            hlc_pkg::OP_TO_BITS:
            begin
                for (int i = 0; i < hlc_pkg::MAX_WORDS; i++)
                    if (active[i])
                        nxt[i] = shl[i];
            end
            default:
            begin
                nxt = cur;
            end
        endcase

        flags.err   = (op == hlc_pkg::OP_ADD) && err;
        flags.trial = (op == hlc_pkg::OP_ADD) && (limit_offset != '0)
                      && (limit_exponent != '0);
    end

endmodule

// ----- design/hlc_trial.sv -----
// ============================================================================
// hlc_trial
// Offset limit check: adds the offset to a widened copy of the new count.
// ============================================================================
module hlc_trial (
    input  hlc_pkg::words_t                 words,
    input  hlc_pkg::cnt_t                   n,
    input  logic [hlc_pkg::EXP_W-1:0]       limit_exponent,
    input  logic [hlc_pkg::OFS_W-1:0]       limit_offset,
    input  logic                            enable,
    output logic                            fail
);

    logic [hlc_pkg::WORD_W:0]           sum0;
    logic [hlc_pkg::MAX_WORDS-1:0]      ovf;
    logic [hlc_pkg::MAX_WORDS-1:0]      reach;
    logic [hlc_pkg::MAX_WORDS-1:0]      hit;
    logic [hlc_pkg::WIDX_W-1:0]         idx;
    hlc_pkg::word_t                     lim;

    // the extra zero top word can never exceed the limit, so it is not modeled
    always_comb
    begin
        idx  = hlc_pkg::limit_index(limit_exponent);
        lim  = hlc_pkg::limit_value(limit_exponent);
        sum0 = {1'b0, words[0]} + (hlc_pkg::WORD_W + 1)'(limit_offset);
        for (int i = 0; i < hlc_pkg::MAX_WORDS; i++)
            ovf[i] = &words[i];
        ovf[0]   = sum0[hlc_pkg::WORD_W];
        reach[0] = 1'b1;
        for (int i = 1; i < hlc_pkg::MAX_WORDS; i++)
            reach[i] = reach[i-1] & ovf[i-1];
        for (int i = 0; i < hlc_pkg::MAX_WORDS; i++)
            hit[i] = (int'(idx) == i) && (hlc_pkg::CNT_W'(i) < n) && reach[i]
                     && (words[i] > lim);
        fail = enable && (|hit);
    end

endmodule

// ----- design/hash_length_counter_with_limit.sv -----
// ============================================================================
// hash_length_counter_with_limit
// Multiword message length counter with add, clear and byte-to-bit convert.
// ============================================================================
// One operation beat in, one result beat out, in order. The block takes a new
// beat every cycle unless back-pressure stalls it: a beat waits in the input
// register, the counter is updated as it moves on (add with carry ripple and
// the direct limit check, clear, or shift left by three), and the offset limit
// check runs on the stage B snapshot of the new count as the result register
// loads. Stages A, B and C are registered in that order; each stage holds while
// the one after it is full, so input is still taken while a result waits.
// Counter words are 32 bits, up to four in use (word_count); count_low carries
// words 1:0 and count_high words 3:2. Configuration writes are meant for an idle
// block; writing word_count also zeroes the counter.
// ============================================================================
module hash_length_counter_with_limit (
    input  logic                                clk,
    input  logic                                rst_n,
    hlc_in_if.sink                              item,
    hlc_out_if.source                           result,
    input  logic                                cfg_we,
    input  logic [hlc_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [hlc_pkg::CFG_DATA_W-1:0]      cfg_data
);

    // configuration
    logic [hlc_pkg::WC_W-1:0]   word_count_reg;
    logic [hlc_pkg::EXP_W-1:0]  limit_exp_reg;
    logic [hlc_pkg::OFS_W-1:0]  limit_ofs_reg;
    hlc_pkg::cnt_t              n_words;

    // counter state
    hlc_pkg::words_t            count_reg;
    hlc_pkg::words_t            count_next;
    hlc_pkg::upd_flags_t        upd_flags;

    // stage A: input register
    logic                       a_valid_reg;
    logic [hlc_pkg::OP_W-1:0]   a_op_reg;
    logic [hlc_pkg::LEN_W-1:0]  a_len_reg;

    // stage B: snapshot of the updated count
    logic                       b_valid_reg;
    hlc_pkg::words_t            b_words_reg;
    hlc_pkg::upd_flags_t        b_flags_reg;

    // stage C: result register
    logic                       c_valid_reg;
    logic                       c_status_reg;
    logic [hlc_pkg::OUT_W-1:0]  c_low_reg;
    logic [hlc_pkg::OUT_W-1:0]  c_high_reg;

    logic                       trial_fail;
    logic                       a_load;
    logic                       b_load;
    logic                       c_load;
    logic                       a_ready;
    logic                       b_ready;
    logic                       wc_write;
    logic [3:0][hlc_pkg::WORD_W-1:0] out_slot;

    assign n_words  = hlc_pkg::active_words(word_count_reg);
    assign wc_write = cfg_we && (cfg_index == hlc_pkg::REG_WORD_COUNT);

    // stage handshakes: a stage loads when empty or when its content moves on
    assign c_load  = b_valid_reg && (!c_valid_reg || result.ready);
    assign b_ready = !b_valid_reg || !c_valid_reg || result.ready;
    assign b_load  = a_valid_reg && b_ready;
    assign a_ready = !a_valid_reg || b_ready;
    assign a_load  = item.valid && a_ready;
    assign item.ready = a_ready;

    hlc_update u_update (
        .cur            (count_reg),
        .n              (n_words),
        .op             (a_op_reg),
        .add_length     (a_len_reg),
        .limit_exponent (limit_exp_reg),
        .limit_offset   (limit_ofs_reg),
        .nxt            (count_next),
        .flags          (upd_flags)
    );

    hlc_trial u_trial (
        .words          (b_words_reg),
        .n              (n_words),
        .limit_exponent (limit_exp_reg),
        .limit_offset   (limit_ofs_reg),
        .enable         (b_flags_reg.trial),
        .fail           (trial_fail)
    );

    // output word slots; words past the array depth read as zero
    for (genvar s = 0; s < 4; s++)
    begin : g_slot
        if (s < hlc_pkg::MAX_WORDS)
        begin : g_word
            assign out_slot[s] = b_words_reg[s];
        end
        else
        begin : g_zero
            assign out_slot[s] = '0;
        end
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            word_count_reg <= hlc_pkg::WORD_COUNT_RST;
            limit_exp_reg  <= '0;
            limit_ofs_reg  <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                hlc_pkg::REG_WORD_COUNT: word_count_reg <= cfg_data[hlc_pkg::WC_W-1:0];
                hlc_pkg::REG_LIMIT_EXP:  limit_exp_reg  <= cfg_data[hlc_pkg::EXP_W-1:0];
                hlc_pkg::REG_LIMIT_OFS:  limit_ofs_reg  <= cfg_data[hlc_pkg::OFS_W-1:0];
                default:                 limit_ofs_reg  <= limit_ofs_reg;
            endcase
        end
    end

    // counter state: updated as a beat leaves stage A
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            count_reg <= '0;
        else if (wc_write)
            count_reg <= '0;
        else if (b_load)
            count_reg <= count_next;
    end

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
        end
        else
        begin
            a_valid_reg <= a_load | (a_valid_reg & ~b_load);
            b_valid_reg <= b_load | (b_valid_reg & ~c_load);
            c_valid_reg <= c_load | (c_valid_reg & ~result.ready);
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (a_load)
        begin
            a_op_reg  <= item.op;
            a_len_reg <= item.add_length;
        end
        if (b_load)
        begin
            b_words_reg <= count_next;
            b_flags_reg <= upd_flags;
        end
        if (c_load)
        begin
            c_status_reg <= b_flags_reg.err | trial_fail;
            c_low_reg    <= {out_slot[1], out_slot[0]};
            c_high_reg   <= {out_slot[3], out_slot[2]};
        end
    end

    assign result.valid      = c_valid_reg;
    assign result.status     = c_status_reg;
    assign result.count_low  = c_low_reg;
    assign result.count_high = c_high_reg;

    // counter only moves on an operation or a word_count write
    a_count_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !b_load && !wc_write |=> $stable(count_reg))
        else $error("counter changed without an operation");

    // word_count write leaves the counter at zero
    a_wc_clear: assert property (@(posedge clk) disable iff (!rst_n)
        wc_write |=> (count_reg == '0))
        else $error("counter not cleared by word_count write");

    // direct and offset checks never apply to the same beat
    a_check_excl: assert property (@(posedge clk) disable iff (!rst_n)
        b_valid_reg |-> !(b_flags_reg.err && b_flags_reg.trial))
        else $error("direct and offset limit checks both active");

    // a beat in stage B always moves into an empty result register
    a_b_drain: assert property (@(posedge clk) disable iff (!rst_n)
        b_valid_reg && !c_valid_reg |=> c_valid_reg)
        else $error("result register failed to load");

endmodule
